// File: sv/rans_interleaved_encoder_unit_assert.svh
// Assertion macros used by the encoder controller.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef RANS_INTERLEAVED_ENCODER_UNIT_ASSERT_SVH
`define RANS_INTERLEAVED_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rie_pkg.sv
`timescale 1ns / 1ps
package rie_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } rie_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TABLE = 2'd1,
        ST_ZERO_FREQ = 2'd2
    } rie_status_t;

    localparam logic [2:0] BYTES_NONE  = 3'd0;
    localparam logic [2:0] BYTES_RENORM = 3'd2;
    localparam logic [2:0] BYTES_FLUSH = 3'd4;

    localparam logic [31:0] LANE_INIT = 32'h0001_0000;
    localparam int          TOTAL_W   = 21;
    localparam int          FREQ_W    = 13;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_load;
        logic accept_enc;
        logic flush_init;
        logic mark_zero;
        logic div_init;
        logic div_step;
        logic mul;
        logic upd;
        logic emit_enc;
        logic emit_flush;
    } rie_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic table_valid;
        logic freq_zero;
        logic div_last;
        logic flush_last;
    } rie_sts_t;

endpackage

// File: sv/rie_req_if.sv
`timescale 1ns / 1ps
interface rie_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  symbol;
    logic [12:0] frequency;
    logic [2:0]  lane;

    modport source (output valid, output operation, output symbol, output frequency,
                    output lane, input ready);
    modport sink (input valid, input operation, input symbol, input frequency,
                  input lane, output ready);
endinterface

// File: sv/rie_rsp_if.sv
`timescale 1ns / 1ps
interface rie_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] chunk;
    logic [2:0]  chunk_bytes;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output chunk, output chunk_bytes, output status,
                    output last, input ready);
    modport sink (input valid, input chunk, input chunk_bytes, input status,
                  input last, output ready);
endinterface

// File: sv/rans_interleaved_encoder_unit.sv
`timescale 1ns / 1ps
// Load: no result. Encode: read, divide (one-bit-per-cycle restoring divider),
// multiply and lane update, or straight to the result on a bad table or zero
// frequency; the result is offered once the output slot is free, and the next
// item is taken after that. Flush: one result per cycle while the output is drained.
// Reset (rst_n low, asynchronous) sets every lane to 65536, clears the running
// total and marks the table invalid; the table memory itself is not cleared.
module rans_interleaved_encoder_unit #(
    parameter int LANES      = 8,
    parameter int SCALE_BITS = 12,
    parameter int SYMBOLS    = 256
) (
    input logic       clk,
    input logic       rst_n,
    rie_req_if.sink   req,
    rie_rsp_if.source rsp
);
    import rie_pkg::*;

    // The controller sequences each encode through table read, divide, multiply
    // and lane update; the datapath holds the table, lane states and the
    // output register, so a finished result can wait while the next load is
    // taken.
    rie_cmd_t cmd;
    rie_sts_t sts;

    rie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .operation (rie_op_t'(req.operation)),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rie_datapath #(
        .LANES      (LANES),
        .SCALE_BITS (SCALE_BITS),
        .SYMBOLS    (SYMBOLS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .symbol      (req.symbol),
        .frequency   (req.frequency),
        .lane        (req.lane),
        .chunk       (rsp.chunk),
        .chunk_bytes (rsp.chunk_bytes),
        .status      (rsp.status),
        .last        (rsp.last)
    );

endmodule

// File: sv/rie_ctrl.sv
`timescale 1ns / 1ps
`include "rans_interleaved_encoder_unit_assert.svh"
module rie_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  rie_pkg::rie_op_t  operation,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rie_pkg::rie_cmd_t cmd,
    input  rie_pkg::rie_sts_t sts
);
    import rie_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_MUL,
        S_UPD,
        S_EMIT,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   accept;
    logic   slot_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_LOAD:
                        begin
                            cmd.accept_load = 1'b1;
                        end
                        OP_ENCODE:
                        begin
                            cmd.accept_enc = 1'b1;
                            state_next     = sts.table_valid ? S_READ : S_EMIT;
                        end
                        OP_FLUSH:
                        begin
                            cmd.flush_init = 1'b1;
                            state_next     = S_FLUSH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (sts.freq_zero)
                begin
                    cmd.mark_zero = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit_enc = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    cmd.emit_flush = 1'b1;
                    if (sts.flush_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit_enc || cmd.emit_flush)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `RIE_ASSERT_NOW(a_emit_slot, (cmd.emit_enc || cmd.emit_flush), (!rsp_valid_reg || rsp_ready), "result written over a pending transfer")
    `RIE_ASSERT_NEXT(a_flush_end, (cmd.emit_flush && sts.flush_last), (state_reg == S_IDLE), "flush did not end after the lowest lane")
    `RIE_ASSERT_NEXT(a_div_end, (state_reg == S_DIV && sts.div_last), (state_reg == S_MUL), "divider did not hand over to the multiply step")
    `RIE_ASSERT_NOW(a_no_accept_busy, (state_reg != S_IDLE), (!req_ready), "input taken while an item is in progress")

endmodule

// File: sv/rie_datapath.sv
`timescale 1ns / 1ps
module rie_datapath #(
    parameter int LANES      = 8,
    parameter int SCALE_BITS = 12,
    parameter int SYMBOLS    = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rie_pkg::rie_cmd_t  cmd,
    output rie_pkg::rie_sts_t  sts,
    input  logic [7:0]         symbol,
    input  logic [12:0]        frequency,
    input  logic [2:0]         lane,
    output logic [31:0]        chunk,
    output logic [2:0]         chunk_bytes,
    output logic [1:0]         status,
    output logic               last
);
    import rie_pkg::*;

    localparam int LIDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int QW      = 32 - SCALE_BITS;
    localparam int CNT_W   = $clog2(QW + 1);
    localparam int ENTRY_W = FREQ_W + SCALE_BITS;
    localparam logic [TOTAL_W-1:0] SCALE_T   = TOTAL_W'(1 << SCALE_BITS);
    localparam logic [15:0]        SCALE_16  = 16'(1 << SCALE_BITS);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Table memory: frequency in the upper bits, cumulative bias below.
    logic [ENTRY_W-1:0] tbl_mem [SYMBOLS];
    logic [ENTRY_W-1:0] tbl_q;

    logic [31:0]        lane_reg [LANES];
    logic [TOTAL_W-1:0] total_reg;
    logic               valid_reg;
    logic [LIDX_W-1:0]  flush_idx_reg;

    logic [LIDX_W-1:0]  lane_q;
    logic               sym_ok_q;
    logic [31:0]        xs_reg;
    logic [12:0]        rem_reg;
    logic [QW-1:0]      dq_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [31:0]        prod_reg;
    logic [31:0]        res_chunk_reg;
    logic [2:0]         res_bytes_reg;
    rie_status_t        res_status_reg;
    logic [31:0]        chunk_reg;
    logic [2:0]         bytes_reg;
    rie_status_t        status_reg;
    logic               last_reg;

    logic [3:0]          lane_mod;
    logic [LIDX_W-1:0]   lane_idx;
    logic                sym_ok;
    logic [SYM_W-1:0]    addr;
    logic [TOTAL_W-1:0]  total_base;
    logic [TOTAL_W:0]    total_sum;
    logic [TOTAL_W-1:0]  total_next;
    logic [FREQ_W-1:0]   f_q;
    logic [SCALE_BITS-1:0] bias_q;
    logic [LIDX_W-1:0]   rd_idx;
    logic [31:0]         x_rd;
    logic                renorm;
    logic [31:0]         xs;
    logic [13:0]         trial;
    logic                trial_ge;
    logic [15:0]         f16;
    logic [15:0]         cmpl;

    // Lane number reduced modulo the lane count by repeated subtraction.
    always_comb
    begin
        lane_mod = {1'b0, lane};
        for (int k = 0; k < 8; k++)
        begin
            if (32'(lane_mod) >= LANES)
            begin
                lane_mod = lane_mod - 4'(LANES);
            end
        end
        lane_idx = LIDX_W'(lane_mod);
    end

    assign sym_ok = (9'(symbol) < 9'(SYMBOLS));
    assign addr   = symbol[SYM_W-1:0];

    assign total_base = (symbol == 8'd0) ? '0 : total_reg;
    assign total_sum  = {1'b0, total_base} + (TOTAL_W + 1)'(frequency);
    assign total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

    assign f_q    = tbl_q[ENTRY_W-1:SCALE_BITS];
    assign bias_q = tbl_q[SCALE_BITS-1:0];

    assign rd_idx = cmd.emit_flush ? flush_idx_reg : lane_q;
    assign x_rd   = lane_reg[rd_idx];
    assign renorm = (45'(x_rd) >= (45'(f_q) << QW));
    assign xs     = renorm ? (x_rd >> 16) : x_rd;

    assign trial    = {rem_reg, dq_reg[QW-1]};
    assign trial_ge = (trial >= {1'b0, f_q});

    assign f16  = 16'(f_q);
    assign cmpl = (f16 <= SCALE_16) ? (SCALE_16 - f16) : 16'd0;

    assign sts.table_valid = valid_reg;
    assign sts.freq_zero   = !sym_ok_q || (f_q == '0);
    assign sts.div_last    = (cnt_reg == CNT_W'(1));
    assign sts.flush_last  = (flush_idx_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.accept_load && sym_ok)
        begin
            tbl_mem[addr] <= {frequency, total_base[SCALE_BITS-1:0]};
        end
        if (cmd.accept_enc)
        begin
            tbl_q <= tbl_mem[addr];
        end
    end

    // Architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                lane_reg[k] <= LANE_INIT;
            end
            total_reg     <= '0;
            valid_reg     <= 1'b0;
            flush_idx_reg <= '0;
        end
        else
        begin
            if (cmd.accept_load && sym_ok)
            begin
                total_reg <= total_next;
                valid_reg <= (total_next == SCALE_T);
            end
            if (cmd.flush_init)
            begin
                flush_idx_reg <= LIDX_W'(LANES - 1);
            end
            if (cmd.emit_flush)
            begin
                lane_reg[flush_idx_reg] <= LANE_INIT;
                flush_idx_reg           <= flush_idx_reg - LIDX_W'(1);
            end
            if (cmd.upd)
            begin
                lane_reg[lane_q] <= xs_reg + 32'(bias_q) + prod_reg;
            end
        end
    end

    // Working registers of one encode.
    always_ff @(posedge clk)
    begin
        if (cmd.accept_enc)
        begin
            lane_q         <= lane_idx;
            sym_ok_q       <= sym_ok;
            res_chunk_reg  <= '0;
            res_bytes_reg  <= BYTES_NONE;
            res_status_reg <= valid_reg ? ST_OK : ST_BAD_TABLE;
        end
        if (cmd.mark_zero)
        begin
            res_status_reg <= ST_ZERO_FREQ;
        end
        if (cmd.div_init)
        begin
            res_chunk_reg <= renorm ? {16'd0, x_rd[15:0]} : 32'd0;
            res_bytes_reg <= renorm ? BYTES_RENORM : BYTES_NONE;
            xs_reg        <= xs;
            rem_reg       <= 13'(xs >> QW);
            dq_reg        <= xs[QW-1:0];
            cnt_reg       <= CNT_W'(QW);
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? 13'(trial - {1'b0, f_q}) : trial[12:0];
            dq_reg  <= {dq_reg[QW-2:0], trial_ge};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.mul)
        begin
            prod_reg <= 32'(32'(dq_reg) * 32'(cmpl));
        end
        if (cmd.emit_enc)
        begin
            chunk_reg  <= res_chunk_reg;
            bytes_reg  <= res_bytes_reg;
            status_reg <= res_status_reg;
            last_reg   <= 1'b1;
        end
        if (cmd.emit_flush)
        begin
            chunk_reg  <= x_rd;
            bytes_reg  <= BYTES_FLUSH;
            status_reg <= ST_OK;
            last_reg   <= (flush_idx_reg == '0);
        end
    end

    assign chunk       = chunk_reg;
    assign chunk_bytes = bytes_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

// File: sim/rans_interleaved_encoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the interleaved rANS encoder unit. A short directed
// run walks through the special cases, and then random episodes follow. Most
// episodes load a small table that sums to 4096 and encode into random lanes.
// The rest are broken tables, unused operation codes and flushes. Both ends of
// the design idle in random bursts. A scoreboard predicts every response from
// its own copy of the tables and lane states.
module rans_interleaved_encoder_unit_test;
    import rie_pkg::*;

    // One request item as the sender offers it. drain_first makes the sender
    // wait, outside the quiet phase, until every expected response has arrived.
    typedef struct {
        rie_op_t     op;
        logic [7:0]  symbol;
        logic [12:0] frequency;
        logic [2:0]  lane;
        bit          drain_first;
    } coder_request_t;

    typedef struct {
        logic [31:0] chunk;
        logic [2:0]  nbytes;
        rie_status_t status;
        logic        last;
    } coder_response_t;

    // The scoreboard holds a private model of the coder. note_request() updates
    // the model for each accepted request and queues the responses it causes.
    // check_response() compares each accepted response with the oldest entry.
    class coder_scoreboard;
        logic [12:0]     freq_mem [256];
        logic [11:0]     bias_mem [256];
        logic [31:0]     lane_state [8];
        logic [20:0]     running_total;
        bit              table_ok;
        coder_response_t pending_q [$];
        int              mismatches;
        int              responses;
        int              encodes;
        int              renorms;
        int              bad_tables;
        int              zero_freqs;
        int              flushes;

        function new();
            for (int k = 0; k < 8; k++)
                lane_state[k] = LANE_INIT;
            running_total = '0;
            table_ok = 1'b0;
        endfunction

        function void push_response(logic [31:0] c, logic [2:0] b, rie_status_t s, logic l);
            coder_response_t r;
            r.chunk = c;
            r.nbytes = b;
            r.status = s;
            r.last = l;
            pending_q.push_back(r);
        endfunction

        function void note_request(coder_request_t it);
            longint unsigned x;
            logic [31:0]     f;
            logic [31:0]     cmpl;
            logic [31:0]     q;
            logic [31:0]     sum;
            logic [31:0]     chunk;
            logic [2:0]      nb;
            case (it.op)
                OP_LOAD:
                begin
                    if (it.symbol == 8'd0)
                        running_total = '0;
                    freq_mem[it.symbol] = it.frequency;
                    bias_mem[it.symbol] = running_total[11:0];
                    sum = 32'(running_total) + 32'(it.frequency);
                    running_total = (sum > 32'h1F_FFFF) ? 21'h1F_FFFF : sum[20:0];
                    table_ok = (running_total == 21'd4096);
                end
                OP_ENCODE:
                begin
                    encodes++;
                    if (!table_ok)
                    begin
                        bad_tables++;
                        push_response('0, BYTES_NONE, ST_BAD_TABLE, 1'b1);
                    end
                    else if (freq_mem[it.symbol] == '0)
                    begin
                        zero_freqs++;
                        push_response('0, BYTES_NONE, ST_ZERO_FREQ, 1'b1);
                    end
                    else
                    begin
                        f = 32'(freq_mem[it.symbol]);
                        x = 64'(lane_state[it.lane]);
                        chunk = '0;
                        nb = BYTES_NONE;
                        // Renormalize when the state would overflow 32 bits.
                        if (x >= (64'(f) << 20))
                        begin
                            chunk = {16'd0, x[15:0]};
                            nb = BYTES_RENORM;
                            x = x >> 16;
                            renorms++;
                        end
                        cmpl = (f <= 32'd4096) ? 32'd4096 - f : 32'd0;
                        q = 32'(x) / f;
                        lane_state[it.lane] = 32'(x) + 32'(bias_mem[it.symbol]) + q * cmpl;
                        push_response(chunk, nb, ST_OK, 1'b1);
                    end
                end
                OP_FLUSH:
                begin
                    flushes++;
                    for (int k = 7; k >= 0; k--)
                    begin
                        push_response(lane_state[k], BYTES_FLUSH, ST_OK, k == 0);
                        lane_state[k] = LANE_INIT;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void report_mismatch(string what, coder_response_t e, coder_response_t a);
            mismatches++;
            if (mismatches <= 10)
            begin
                $write("%0t: %s: expected chunk %h bytes %0d status %0d last %0d,",
                       $realtime, what, e.chunk, e.nbytes, e.status, e.last);
                $display(" got chunk %h bytes %0d status %0d last %0d",
                         a.chunk, a.nbytes, a.status, a.last);
            end
        endfunction

        function void check_response(coder_response_t a);
            coder_response_t e;
            responses++;
            if (pending_q.size() == 0)
            begin
                e.chunk = 'x;
                e.nbytes = 'x;
                e.status = ST_OK;
                e.last = 'x;
                report_mismatch("unexpected response", e, a);
                return;
            end
            e = pending_q.pop_front();
            if (a.chunk !== e.chunk || a.nbytes !== e.nbytes ||
                a.status !== e.status || a.last !== e.last)
                report_mismatch("response mismatch", e, a);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rie_req_if req ();
    rie_rsp_if rsp ();

    rans_interleaved_encoder_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    coder_scoreboard coder_sb;
    coder_request_t  request_list [$];

    // Generator-side memory of which table entries have been loaded, so that
    // no encode ever reads an entry that was never written.
    bit              loaded [256];
    byte unsigned    loaded_syms [$];

    // Stimulus controls; quiet_phase and long_hold are shared with the receiver process.
    bit quiet_phase;
    bit long_hold;
    int directed_count;

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Hard limit on the run: far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void add_request(rie_op_t op, int sym, int freq, int ln, bit drain = 1'b0);
        coder_request_t it;
        it.op = op;
        it.symbol = 8'(sym);
        it.frequency = 13'(freq);
        it.lane = 3'(ln);
        it.drain_first = drain;
        request_list.push_back(it);
        if (op == OP_LOAD && !loaded[sym])
        begin
            loaded[sym] = 1'b1;
            loaded_syms.push_back(byte'(sym));
        end
    endfunction

    // A small table: index 0 restarts the sum, then a few ascending indices.
    // The frequencies split 4096 at random, with zero entries now and then.
    function automatic void add_table(int entries);
        int remaining;
        int sym;
        int f;
        remaining = 4096;
        sym = 0;
        for (int k = 0; k < entries; k++)
        begin
            if (k == entries - 1)
                f = remaining;
            else if ($urandom_range(0, 4) == 0)
                f = 0;
            else
                f = $urandom_range(0, remaining);
            remaining -= f;
            add_request(OP_LOAD, sym, f, $urandom_range(0, 7));
            if (k < entries - 1)
                sym = $urandom_range(sym + 1, 255 - (entries - 2 - k));
        end
    endfunction

    function automatic void add_encodes(int count);
        for (int k = 0; k < count; k++)
            add_request(OP_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                        $urandom_range(0, 8191), $urandom_range(0, 7));
    endfunction

    function automatic void build_stimulus();
        int pick;
        // Encode against an unfinished table, then an unused operation code.
        add_request(OP_LOAD, 0, 5, 0);
        add_request(OP_ENCODE, 0, 0, 0);
        add_request(OP_NONE, 255, 8191, 7);
        // Table with a single symbol of full probability, at the top index.
        add_request(OP_LOAD, 0, 0, 0);
        add_request(OP_LOAD, 255, 4096, 0);
        add_request(OP_ENCODE, 0, 0, 5);
        add_request(OP_ENCODE, 255, 0, 7);
        // Frequency one forces renormalization on repeated encodes.
        add_request(OP_LOAD, 0, 1, 0);
        add_request(OP_LOAD, 1, 4095, 0);
        for (int k = 0; k < 5; k++)
            add_request(OP_ENCODE, 0, 0, 0);
        add_request(OP_ENCODE, 1, 8191, 3);
        add_request(OP_FLUSH, 0, 0, 0);
        // An oversized frequency breaks the sum, then a restart repairs it.
        add_request(OP_LOAD, 2, 8191, 0);
        add_request(OP_ENCODE, 1, 0, 1);
        add_request(OP_LOAD, 0, 4096, 0, 1'b1);
        add_request(OP_ENCODE, 0, 0, 6);
        add_request(OP_FLUSH, 0, 0, 0);
        directed_count = request_list.size();
        // Flushes and encodes right away, so the long receiver hold fills up.
        add_encodes(4);
        add_request(OP_FLUSH, 0, 0, 0);
        add_request(OP_FLUSH, 0, 0, 0);
        add_encodes(3);
        while (request_list.size() < 220)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                add_table($urandom_range(2, 8));
                add_encodes($urandom_range(4, 14));
                if ($urandom_range(0, 2) == 0)
                    add_request(OP_FLUSH, $urandom_range(0, 255), 0, $urandom_range(0, 7));
            end
            else if (pick < 8)
            begin
                // Noise: stray loads, unused operation codes, encodes.
                add_request(OP_LOAD, $urandom_range(1, 255), $urandom_range(0, 8191),
                            $urandom_range(0, 7));
                add_request(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 8191),
                            $urandom_range(0, 7));
                add_encodes($urandom_range(1, 4));
            end
            else
                add_request(OP_FLUSH, 0, 0, 0, $urandom_range(0, 1));
        end
    endfunction

    // Offer one request and return once it has been transferred.
    task automatic send_request(coder_request_t it);
        req.valid = 1'b1;
        req.operation = it.op;
        req.symbol = it.symbol;
        req.frequency = it.frequency;
        req.lane = it.lane;
        do
            @(posedge clk);
        while (!req.ready);
        coder_sb.note_request(it);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        while (coder_sb.pending_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_sender();
        int gap;
        for (int n = 0; n < request_list.size(); n++)
        begin
            if (n == directed_count)
                long_hold = 1'b1;
            if (n >= request_list.size() - 40)
                quiet_phase = 1'b1;
            if (request_list[n].drain_first && !quiet_phase)
            begin
                req.valid = 1'b0;
                wait_for_drain();
            end
            // Random idle bursts between transfers.
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                req.valid = 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap)
                    @(negedge clk);
            end
            send_request(request_list[n]);
        end
        req.valid = 1'b0;
    endtask

    // The receiver stalls in random bursts, holds off for a long stretch once,
    // and stays ready throughout the quiet phase at the end.
    initial
    begin
        int burst;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp.ready = 1'b0;
                repeat (400)
                    @(negedge clk);
                long_hold = 1'b0;
            end
            if (quiet_phase)
                rsp.ready = 1'b1;
            else
            begin
                burst = $urandom_range(1, 19);
                rsp.ready = ($urandom_range(0, 3) != 0);
                repeat (burst - 1)
                    @(negedge clk);
            end
        end
    end

    // Every response transfer goes straight to the scoreboard.
    always @(posedge clk)
    begin
        coder_response_t seen;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            seen.chunk = rsp.chunk;
            seen.nbytes = rsp.chunk_bytes;
            seen.status = rie_status_t'(rsp.status);
            seen.last = rsp.last;
            coder_sb.check_response(seen);
        end
    end

    initial
    begin
        coder_sb = new();
        quiet_phase = 1'b0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_NONE;
        req.symbol = '0;
        req.frequency = '0;
        req.lane = '0;
        build_stimulus();
        repeat (12)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        run_sender();
        // Let the last results drain, then allow time for anything spurious.
        wait_for_drain();
        repeat (60)
            @(negedge clk);
        $write("Sent %0d requests: %0d encodes (%0d renormalized, ",
               request_list.size(), coder_sb.encodes, coder_sb.renorms);
        $display("%0d bad table, %0d zero frequency), %0d flushes.",
                 coder_sb.bad_tables, coder_sb.zero_freqs, coder_sb.flushes);
        $display("Checked %0d responses, %0d mismatches.", coder_sb.responses,
                 coder_sb.mismatches);
        if (coder_sb.mismatches == 0 && coder_sb.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
